// ===== rtl/core/i2cm_pkg.sv =====
package i2cm_pkg;

   // Command codes carried in the op field.
   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_STOP  = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // Item kinds.
   localparam logic KIND_COMMAND = 1'b0;
   localparam logic KIND_TICK    = 1'b1;

   // Half-period bookkeeping: eight data bits take sixteen half-periods,
   // followed by two half-periods of the ack clock.
   localparam int unsigned BitsPerByte = 8;
   localparam logic [4:0] DATA_HALVES = 5'(2 * BitsPerByte);
   localparam logic [4:0] LAST_HALF   = 5'(2 * BitsPerByte + 1);

   // One input item.
   typedef struct packed {
      logic       kind;
      logic [1:0] op;
      logic [7:0] data_byte;
      logic       ack_to_send;
      logic       sda_in;
   } req_type;

   // One result item.
   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_received;
      logic       command_rejected;
   } rsp_type;

   // Handshake between the input register and the output register.
   typedef struct packed {
      logic take;
   } flow_type;

endpackage

// ===== rtl/core/i2cm_in_reg.sv =====
module i2cm_in_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  i2cm_pkg::req_type req_payload,
   input  logic              take,
   output logic              item_valid,
   output i2cm_pkg::req_type item
);

   logic              item_valid_ff;
   logic              item_valid_in;
   i2cm_pkg::req_type item_ff;
   logic              req_accept;

   // The register takes a new transfer whenever it is empty or being drained.
   assign req_stall  = item_valid_ff && !take;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         item_valid_in = 1'b1;
      end else if (take) begin
         item_valid_in = 1'b0;
      end else begin
         item_valid_in = item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_payload;
      end
   end

   assign item_valid = item_valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/core/i2cm_seq.sv =====
module i2cm_seq (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  i2cm_pkg::req_type item,
   output i2cm_pkg::rsp_type result
);

   logic [1:0] operation_ff, operation_in;
   logic [4:0] half_ff, half_in;
   logic [7:0] shift_ff, shift_in;
   logic       pending_ack_ff, pending_ack_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;
   logic       busy_ff, busy_in;
   logic       last_ack_ff, last_ack_in;
   logic [7:0] last_read_ff, last_read_in;
   logic       done;
   logic       rejected;
   logic       finish;
   logic       bump;

   // Next sequencer state for the item at the head of the input register.
   always_comb begin
      operation_in   = operation_ff;
      half_in        = half_ff;
      shift_in       = shift_ff;
      pending_ack_in = pending_ack_ff;
      scl_in         = scl_ff;
      sda_in         = sda_ff;
      busy_in        = busy_ff;
      last_ack_in    = last_ack_ff;
      last_read_in   = last_read_ff;
      done           = 1'b0;
      rejected       = 1'b0;
      finish         = 1'b0;
      bump           = 1'b0;

      if (item.kind == i2cm_pkg::KIND_COMMAND) begin
         if (busy_ff) begin
            rejected = 1'b1;
         end else begin
            // Load a new command and present its first half-period.
            operation_in   = item.op;
            half_in        = '0;
            pending_ack_in = item.ack_to_send;
            busy_in        = 1'b1;
            scl_in         = 1'b1;
            case (item.op)
               i2cm_pkg::OP_START: begin
                  sda_in = 1'b1;
               end
               i2cm_pkg::OP_STOP: begin
                  sda_in = 1'b0;
               end
               i2cm_pkg::OP_WRITE: begin
                  shift_in = item.data_byte;
                  sda_in   = item.data_byte[7];
               end
               default: begin
                  shift_in = '0;
                  sda_in   = 1'b1;
               end
            endcase
         end
      end else if (busy_ff) begin
         // A tick ends the current half-period.
         case (operation_ff)
            i2cm_pkg::OP_START: begin
               if (half_ff == '0) begin
                  sda_in = 1'b0;
                  bump   = 1'b1;
               end else begin
                  scl_in = 1'b0;
                  finish = 1'b1;
               end
            end
            i2cm_pkg::OP_STOP: begin
               if (half_ff == '0) begin
                  sda_in = 1'b1;
                  bump   = 1'b1;
               end else begin
                  finish = 1'b1;
               end
            end
            i2cm_pkg::OP_WRITE: begin
               if (half_ff < i2cm_pkg::DATA_HALVES) begin
                  if (!half_ff[0]) begin
                     scl_in = 1'b0;
                  end else begin
                     // Move to the next bit; the ack clock releases SDA.
                     shift_in = {shift_ff[6:0], 1'b0};
                     scl_in   = 1'b1;
                     if (half_ff + 5'd1 < i2cm_pkg::DATA_HALVES) begin
                        sda_in = shift_ff[6];
                     end else begin
                        sda_in = 1'b1;
                     end
                  end
                  bump = 1'b1;
               end else if (half_ff == i2cm_pkg::DATA_HALVES) begin
                  last_ack_in = item.sda_in;
                  scl_in      = 1'b0;
                  bump        = 1'b1;
               end else begin
                  finish = 1'b1;
               end
            end
            default: begin
               if (half_ff < i2cm_pkg::DATA_HALVES) begin
                  if (!half_ff[0]) begin
                     // Sample on the high half of SCL.
                     shift_in = {shift_ff[6:0], item.sda_in};
                     scl_in   = 1'b0;
                  end else begin
                     scl_in = 1'b1;
                     if (half_ff + 5'd1 < i2cm_pkg::DATA_HALVES) begin
                        sda_in = 1'b1;
                     end else begin
                        sda_in = pending_ack_ff;
                     end
                  end
                  bump = 1'b1;
               end else if (half_ff == i2cm_pkg::DATA_HALVES) begin
                  scl_in = 1'b0;
                  bump   = 1'b1;
               end else begin
                  last_read_in = shift_ff;
                  finish       = 1'b1;
               end
            end
         endcase

         if (finish) begin
            busy_in = 1'b0;
            half_in = '0;
            done    = 1'b1;
         end else if (bump && half_ff < i2cm_pkg::LAST_HALF) begin
            half_in = half_ff + 5'd1;
         end
      end
   end

   // Sequencer state advances only when the item moves to the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         operation_ff   <= i2cm_pkg::OP_START;
         half_ff        <= '0;
         shift_ff       <= '0;
         pending_ack_ff <= 1'b0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         busy_ff        <= 1'b0;
         last_ack_ff    <= 1'b1;
         last_read_ff   <= '0;
      end else if (take) begin
         operation_ff   <= operation_in;
         half_ff        <= half_in;
         shift_ff       <= shift_in;
         pending_ack_ff <= pending_ack_in;
         scl_ff         <= scl_in;
         sda_ff         <= sda_in;
         busy_ff        <= busy_in;
         last_ack_ff    <= last_ack_in;
         last_read_ff   <= last_read_in;
      end
   end

   // The result reflects the state after this item.
   always_comb begin
      result.scl_level        = scl_in;
      result.sda_level        = sda_in;
      result.busy_res         = busy_in;
      result.done_res         = done;
      result.read_byte        = last_read_in;
      result.ack_received     = last_ack_in;
      result.command_rejected = rejected;
   end

`ifndef SYNTHESIS
   a_idle_index_zero : assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> half_ff == '0)
      else $error("half-period index not cleared while idle");

   a_index_bound : assert property (@(posedge clock) disable iff (reset)
      half_ff <= i2cm_pkg::LAST_HALF)
      else $error("half-period index out of range");

   a_short_ops : assert property (@(posedge clock) disable iff (reset)
      busy_ff && (operation_ff == i2cm_pkg::OP_START || operation_ff == i2cm_pkg::OP_STOP)
      |-> half_ff <= 5'd1)
      else $error("start or stop ran past two half-periods");

   a_done_frees : assert property (@(posedge clock) disable iff (reset)
      take && done |=> !busy_ff)
      else $error("sequencer still busy after completing a command");

   a_reject_holds : assert property (@(posedge clock) disable iff (reset)
      take && rejected |=> busy_ff && $stable(half_ff))
      else $error("rejected command disturbed the sequence");
`endif

endmodule

// ===== rtl/core/i2cm_out_reg.sv =====
module i2cm_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              item_valid,
   output i2cm_pkg::flow_type flow,
   input  i2cm_pkg::rsp_type result,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output i2cm_pkg::rsp_type rsp_payload
);

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   i2cm_pkg::rsp_type rsp_ff;
   logic              take;

   // An item moves on when the output register is empty or being emptied.
   assign take      = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign flow.take = take;

   always_comb begin
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_stall) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== rtl/core/i2c_master_byte_engine_core.sv =====
// A transfer accepted on the request side waits in the input register and is shown on the
// result port once the output register, empty or being emptied, takes it.
// Throughput: one item per cycle unless the result side stalls; the sequencer update sits
// between the registers, and its state changes as the item enters the output register.
// Reset: synchronous, active high; both registers empty, lines released, engine idle,
// received ack reads as one and the read byte as zero.
module i2c_master_byte_engine_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  i2cm_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output i2cm_pkg::rsp_type rsp_payload
);

   logic               item_valid;
   i2cm_pkg::req_type  item;
   i2cm_pkg::rsp_type  result;
   i2cm_pkg::flow_type flow;

   // Request register.
   i2cm_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .take        (flow.take),
      .item_valid  (item_valid),
      .item        (item)
   );

   // Bit-level sequencer.
   i2cm_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .take   (flow.take),
      .item   (item),
      .result (result)
   );

   // Result register.
   i2cm_out_reg u_out_reg (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .flow        (flow),
      .result      (result),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
